// ===== rtl/core/bbsf_pkg.sv =====
// Shared constants, types and helpers for the bounded byte stream FIFO.
// No dependencies; the queue, front end, back end and top level import this package.
package bbsf_pkg;

    localparam int DEPTH     = 1024;
    localparam int MAX_BURST = 64;
    localparam int QDEPTH    = 4;

    localparam int AW      = $clog2(DEPTH);
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = OCC_W + 1;
    localparam int LEN_W   = 7;
    localparam int CNT_W   = (OCC_W > LEN_W) ? OCC_W : LEN_W;
    localparam int CAP_W   = 11;
    localparam int QAW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int BC_W    = $clog2(QDEPTH + 2);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_PEEK  = 3'd1,
        CMD_READ  = 3'd2,
        CMD_POP   = 3'd3,
        CMD_END   = 3'd4
    } bbsf_cmd_t;

    typedef struct packed {
        logic        accepted;
        logic [10:0] fill_count;
        logic [10:0] room_left;
        logic [31:0] total_written;
        logic [31:0] total_read;
        logic        ended;
        logic        at_eof;
        logic        error_flag;
    } bbsf_status_t;

    typedef struct packed {
        logic             burst;
        logic [AW-1:0]    start;
        logic [LEN_W-1:0] count;
        bbsf_status_t     status;
    } bbsf_job_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [7:0]    data;
    } bbsf_wr_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
    } bbsf_rd_t;

    // Ring index wrap; the sum is always below twice the depth.
    function automatic logic [AW-1:0] bbsf_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        begin
            if (s >= SUM_W'(DEPTH))
            begin
                r = s - SUM_W'(DEPTH);
            end
            else
            begin
                r = s;
            end
            return r[AW-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/bbsf_channels.sv =====
// Valid/ready channel interfaces for command, result and capacity transfers.
// No dependencies.
interface bbsf_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [6:0] length;

    modport source (output valid, output cmd, output data_byte, output length, input ready);
    modport sink (input valid, input cmd, input data_byte, input length, output ready);
endinterface

interface bbsf_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic        accepted;
    logic [10:0] fill_count;
    logic [10:0] room_left;
    logic [31:0] total_written;
    logic [31:0] total_read;
    logic        ended;
    logic        at_eof;
    logic        error_flag;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output accepted, output fill_count, output room_left,
                    output total_written, output total_read, output ended,
                    output at_eof, output error_flag, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input last,
                  input accepted, input fill_count, input room_left,
                  input total_written, input total_read, input ended,
                  input at_eof, input error_flag, output ready);
endinterface

interface bbsf_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink (input valid, input capacity, output ready);
endinterface

// ===== rtl/core/bbsf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/bbsf_queue.sv =====
// Short job queue between the command front end and the result back end.
// Depends on bbsf_pkg.
module bbsf_queue import bbsf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bbsf_job_t push_job,
    output logic      full,
    output logic      job_valid,
    output bbsf_job_t job,
    input  logic      pop
);

    bbsf_job_t           slots_reg [QDEPTH];
    logic [QAW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = slots_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/bbsf_front.sv =====
// Command front end: takes commands, updates the stream state, writes bytes
// and queues one job per command. Depends on bbsf_pkg and the channel interfaces.
module bbsf_front import bbsf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    bbsf_req_if.sink    req,
    bbsf_cfg_if.sink    cfg,
    input  logic        queue_full,
    output logic        push,
    output bbsf_job_t   push_job,
    input  logic        burst_done,
    output bbsf_wr_t    wr
);

    logic [AW-1:0]    head_reg, head_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [31:0]      wr_cnt_reg, wr_cnt_next;
    logic [31:0]      rd_cnt_reg, rd_cnt_next;
    logic             ended_reg, ended_next;
    logic             err_reg, err_next;
    logic [CAP_W-1:0] capacity_reg;
    logic [BC_W-1:0]  burst_cnt_reg, burst_cnt_next;

    logic             accept;
    logic [LEN_W-1:0] len_c;
    logic [CNT_W-1:0] len_w, occ_w, n;
    logic [OCC_W-1:0] cap_eff, n_occ;
    logic             room_ok, is_burst;
    logic [OCC_W-1:0] room;

    // A write waits while a peek or read still has bytes to fetch, so freed
    // slots are never refilled before the back end has read them.
    assign req.ready = !queue_full &&
                       !((req.cmd == CMD_WRITE) && (burst_cnt_reg != '0));
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        len_c   = (req.length > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : req.length;
        len_w   = CNT_W'(len_c);
        occ_w   = CNT_W'(occ_reg);
        n       = (len_w < occ_w) ? len_w : occ_w;
        n_occ   = OCC_W'(n);
        cap_eff = (32'(capacity_reg) > 32'(DEPTH)) ? OCC_W'(DEPTH) : OCC_W'(capacity_reg);
        room_ok = (occ_reg < cap_eff);

        head_next  = head_reg;
        occ_next   = occ_reg;
        wr_cnt_next = wr_cnt_reg;
        rd_cnt_next = rd_cnt_reg;
        ended_next = ended_reg;
        err_next   = err_reg;
        is_burst   = 1'b0;

        wr.en   = 1'b0;
        wr.addr = bbsf_wrap(SUM_W'(head_reg) + SUM_W'(occ_reg));
        wr.data = req.data_byte;

        push_job.status.accepted = 1'b0;

        unique case (req.cmd)
            CMD_WRITE:
            begin
                if (room_ok)
                begin
                    wr.en       = accept;
                    occ_next    = occ_reg + 1'b1;
                    wr_cnt_next = wr_cnt_reg + 32'd1;
                    push_job.status.accepted = 1'b1;
                end
            end
            CMD_PEEK:
            begin
                is_burst = (n != '0);
            end
            CMD_READ:
            begin
                if (len_w > occ_w)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    is_burst    = (n != '0);
                    head_next   = bbsf_wrap(SUM_W'(head_reg) + SUM_W'(n_occ));
                    occ_next    = occ_reg - n_occ;
                    rd_cnt_next = rd_cnt_reg + 32'(n_occ);
                end
            end
            CMD_POP:
            begin
                if (len_w > occ_w)
                begin
                    err_next = 1'b1;
                end
                head_next   = bbsf_wrap(SUM_W'(head_reg) + SUM_W'(n_occ));
                occ_next    = occ_reg - n_occ;
                rd_cnt_next = rd_cnt_reg + 32'(n_occ);
            end
            CMD_END:
            begin
                ended_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        room = (cap_eff > occ_next) ? cap_eff - occ_next : '0;

        push                          = accept;
        push_job.burst                = is_burst;
        push_job.start                = head_reg;
        push_job.count                = LEN_W'(n);
        push_job.status.fill_count    = 11'(occ_next);
        push_job.status.room_left     = 11'(room);
        push_job.status.total_written = wr_cnt_next;
        push_job.status.total_read    = rd_cnt_next;
        push_job.status.ended         = ended_next;
        push_job.status.at_eof        = ended_next && (occ_next == '0);
        push_job.status.error_flag    = err_next;

        burst_cnt_next = burst_cnt_reg + BC_W'(accept && is_burst) - BC_W'(burst_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            wr_cnt_reg    <= '0;
            rd_cnt_reg    <= '0;
            ended_reg     <= 1'b0;
            err_reg       <= 1'b0;
            capacity_reg  <= CAP_RESET;
            burst_cnt_reg <= '0;
        end
        else
        begin
            burst_cnt_reg <= burst_cnt_next;
            if (cfg.valid)
            begin
                capacity_reg <= cfg.capacity;
            end
            if (accept)
            begin
                head_reg   <= head_next;
                occ_reg    <= occ_next;
                wr_cnt_reg <= wr_cnt_next;
                rd_cnt_reg <= rd_cnt_next;
                ended_reg  <= ended_next;
                err_reg    <= err_next;
            end
        end
    end

endmodule

// ===== rtl/core/bbsf_back.sv =====
// Result back end: takes queued jobs, streams burst bytes out of the byte
// memory and drives the result register. Depends on bbsf_pkg and the interfaces.
module bbsf_back import bbsf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  bbsf_job_t   job,
    output logic        job_pop,
    output bbsf_rd_t    rd,
    input  logic [7:0]  rd_data,
    output logic        burst_done,
    bbsf_rsp_if.source  rsp
);

    typedef enum logic {ST_IDLE, ST_BURST} state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    bbsf_status_t     status_reg, status_next;
    logic             pending_reg, pending_next;
    logic             pend_last_reg, pend_last_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             byte_valid_reg, byte_valid_next;
    logic             last_reg, last_next;
    bbsf_status_t     out_status_reg, out_status_next;

    logic out_free, move, issue;

    always_comb
    begin
        out_free = !out_valid_reg || rsp.ready;
        // pending: the memory output holds a byte not yet in the result register
        move     = pending_reg && out_free;
        issue    = (state_reg == ST_BURST) && (!pending_reg || move);
        job_pop  = (state_reg == ST_IDLE) && !pending_reg && job_valid && out_free;

        state_next      = state_reg;
        addr_next       = addr_reg;
        remain_next     = remain_reg;
        status_next     = status_reg;
        pending_next    = issue ? 1'b1 : (move ? 1'b0 : pending_reg);
        pend_last_next  = issue ? (remain_reg == LEN_W'(1)) : pend_last_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        last_next       = last_reg;
        out_status_next = out_status_reg;

        if (move)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = rd_data;
            byte_valid_next = 1'b1;
            last_next       = pend_last_reg;
            out_status_next = status_reg;
        end

        if (issue)
        begin
            addr_next   = bbsf_wrap(SUM_W'(addr_reg) + SUM_W'(1));
            remain_next = remain_reg - 1'b1;
            if (remain_reg == LEN_W'(1))
            begin
                state_next = ST_IDLE;
            end
        end

        if (job_pop)
        begin
            if (job.burst)
            begin
                state_next  = ST_BURST;
                addr_next   = job.start;
                remain_next = job.count;
                status_next = job.status;
            end
            else
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = 8'd0;
                byte_valid_next = 1'b0;
                last_next       = 1'b1;
                out_status_next = job.status;
            end
        end

        rd.en      = issue;
        rd.addr    = addr_reg;
        burst_done = issue && (remain_reg == LEN_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            addr_reg       <= '0;
            remain_reg     <= '0;
            status_reg     <= '0;
            pend_last_reg  <= 1'b0;
            out_byte_reg   <= '0;
            byte_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
            out_status_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pending_reg    <= pending_next;
            out_valid_reg  <= out_valid_next;
            addr_reg       <= addr_next;
            remain_reg     <= remain_next;
            status_reg     <= status_next;
            pend_last_reg  <= pend_last_next;
            out_byte_reg   <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            last_reg       <= last_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.out_byte      = out_byte_reg;
    assign rsp.byte_valid    = byte_valid_reg;
    assign rsp.last          = last_reg;
    assign rsp.accepted      = out_status_reg.accepted;
    assign rsp.fill_count    = out_status_reg.fill_count;
    assign rsp.room_left     = out_status_reg.room_left;
    assign rsp.total_written = out_status_reg.total_written;
    assign rsp.total_read    = out_status_reg.total_read;
    assign rsp.ended         = out_status_reg.ended;
    assign rsp.at_eof        = out_status_reg.at_eof;
    assign rsp.error_flag    = out_status_reg.error_flag;

endmodule

// ===== rtl/core/bounded_byte_stream_fifo.sv =====
// Top level of the bounded byte stream FIFO: front end, job queue, back end
// and byte memory. Depends on bbsf_pkg, the channel interfaces and all bbsf modules.
//
//   channel  dir  carries                                   transfer when
//   req      in   cmd, data_byte, length                    req.valid && req.ready
//   rsp      out  out_byte, byte_valid, last, status fields rsp.valid && rsp.ready
//   cfg      in   capacity                                  cfg.valid && cfg.ready
//
// Write, pop, end and status-only commands are taken one per cycle while the job queue
// has room and give one result each. A peek or read of n bytes gives its first byte
// via the queue, the memory read register and the result register, then one byte per
// cycle while rsp is ready; the next job starts once the last byte is in the result
// register. A write command is held off while a peek or read still has bytes to
// fetch. Reset clears the pointers, counters and flags at once; the byte memory is
// not cleared. A stalled result fills the four-entry job queue, then stalls req.
module bounded_byte_stream_fifo import bbsf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    bbsf_req_if.sink   req,
    bbsf_rsp_if.source rsp,
    bbsf_cfg_if.sink   cfg
);

    logic       queue_full, push, job_valid, job_pop, burst_done;
    bbsf_job_t  push_job, job;
    bbsf_wr_t   wr;
    bbsf_rd_t   rd;
    logic [7:0] rd_data;

    bbsf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job),
        .burst_done (burst_done),
        .wr         (wr)
    );

    bbsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .job_valid (job_valid),
        .job       (job),
        .pop       (job_pop)
    );

    bbsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (job),
        .job_pop    (job_pop),
        .rd         (rd),
        .rd_data    (rd_data),
        .burst_done (burst_done),
        .rsp        (rsp)
    );

    bbsf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd.en),
        .rd_addr (rd.addr),
        .rd_data (rd_data)
    );

endmodule
